// ===== rtl/core/srhq_pkg.sv =====
package srhq_pkg;

   // Field widths of the stream items.
   localparam int RATE_W    = 16;
   localparam int ELAPSED_W = 20;
   localparam int FILT_W    = 14;
   localparam int SMOOTH_W  = 30;
   localparam int TIMER_W   = 21;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 21;

   // Clamped input ranges.
   localparam int RATE_MAX    = 16000;
   localparam int ELAPSED_MAX = 100000;
   localparam int DT_W        = $clog2(ELAPSED_MAX + 1);
   localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};

   // Reset values of the configuration registers.
   localparam logic [FILT_W-1:0]  ENGAGE_RATE_RST   = FILT_W'(640);
   localparam logic [FILT_W-1:0]  RELEASE_RATE_RST  = FILT_W'(880);
   localparam logic [TIMER_W-1:0] ENGAGE_DWELL_RST  = TIMER_W'(350000);
   localparam logic [TIMER_W-1:0] RELEASE_DWELL_RST = TIMER_W'(1250000);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENGAGE_RATE   = 3'd0,
      CSR_RELEASE_RATE  = 3'd1,
      CSR_ENGAGE_DWELL  = 3'd2,
      CSR_RELEASE_DWELL = 3'd3
   } csr_index_type;

   // The blend table only needs the entries that a clamped elapsed time can reach.
   localparam int BLEND_SHIFT    = 9;
   localparam int BLEND_TAB_SIZE = (ELAPSED_MAX >> BLEND_SHIFT) + 1;
   localparam int BLEND_IDX_W    = $clog2(BLEND_TAB_SIZE);
   localparam int BLEND_W        = 16;

   typedef logic [BLEND_W-1:0] blend_tab_type [BLEND_TAB_SIZE];

   // Entry i holds 1 - exp(-7.5 * i * 512us) in Q0.16, built from a Q0.32
   // series for exp(-x) and repeated rounded multiplication.
   function automatic blend_tab_type blend_tab_init();
      logic [63:0]   x;
      logic [63:0]   t2;
      logic [63:0]   t3;
      logic [63:0]   t4;
      logic [63:0]   r;
      logic [63:0]   e;
      blend_tab_type tab;
      x  = ((64'd12 << 32) + 64'd1562) / 64'd3125;
      t2 = ((x * x) >> 32) / 64'd2;
      t3 = ((t2 * x) >> 32) / 64'd3;
      t4 = ((t3 * x) >> 32) / 64'd4;
      r  = (64'd1 << 32) - x + t2 - t3 + t4;
      e  = 64'd1 << 32;
      for (int i = 0; i < BLEND_TAB_SIZE; i++) begin
         tab[i] = BLEND_W'(((64'd1 << 32) - e + 64'd32768) >> 16);
         e      = (e * r + (64'd1 << 31)) >> 32;
      end
      return tab;
   endfunction

   localparam blend_tab_type BLEND_TAB = blend_tab_init();

endpackage

// ===== rtl/core/srhq_filter.sv =====
module srhq_filter
   import srhq_pkg::*;
#(
   parameter int BLEND_ENTRIES = 256
) (
   input  logic [SMOOTH_W-1:0] smooth,
   input  logic                primed,
   input  logic [FILT_W-1:0]   rate,
   input  logic [DT_W-1:0]     elapsed,
   output logic [SMOOTH_W-1:0] smooth_next,
   output logic                primed_next
);

   // Highest usable table index: the configured entry count or the reach of
   // the clamped elapsed time, whichever is smaller.
   localparam int IDX_LIMIT = (BLEND_ENTRIES - 1 < BLEND_TAB_SIZE - 1) ?
                              (BLEND_ENTRIES - 1) : (BLEND_TAB_SIZE - 1);
   localparam logic [BLEND_IDX_W-1:0] IDX_MAX = BLEND_IDX_W'(IDX_LIMIT);

   logic [BLEND_IDX_W-1:0]       idx_raw;
   logic [BLEND_IDX_W-1:0]       idx;
   logic [BLEND_W-1:0]           blend;
   logic signed [SMOOTH_W:0]     diff;
   logic signed [SMOOTH_W+BLEND_W+1:0] prod;
   logic signed [SMOOTH_W+BLEND_W+1:0] step;
   logic [SMOOTH_W-1:0]          target;

   always_comb begin
      idx_raw = BLEND_IDX_W'(elapsed >> BLEND_SHIFT);
      idx     = (idx_raw > IDX_MAX) ? IDX_MAX : idx_raw;
      blend   = BLEND_TAB[idx];
      target  = {rate, 16'd0};
      diff    = signed'({1'b0, target}) - signed'({1'b0, smooth});
      prod    = diff * signed'({1'b0, blend});
      // Arithmetic shift floors negative steps, matching the rounding of the fold.
      step    = prod >>> 16;

      if (!primed) begin
         smooth_next = target;
         primed_next = (rate != '0);
      end else if (rate != '0) begin
         smooth_next = smooth + step[SMOOTH_W-1:0];
         primed_next = 1'b1;
      end else begin
         smooth_next = smooth;
         primed_next = 1'b1;
      end
   end

endmodule

// ===== rtl/core/smoothed_rate_hysteresis_qualifier_top.sv =====
// Smoothed rate qualifier with hysteresis and dwell timers.
//
// The request stream carries one rate sample per transaction together with the
// time elapsed since the previous sample and the manual and automatic enables.
// Every request transaction produces exactly one response transaction holding
// the filtered rate, the automatic engaged flag and the effective output.
//
// The block is a two-register pipeline: a request is captured in an input
// register, and when that register advances the filter update, the threshold
// compares and the dwell timers run in one pass and load the state and the
// response register, from which the response is offered. One transaction per
// cycle can be sustained in both directions while the receiver does not stall.
//
// When the receiver stalls, the response register holds its transaction and the
// input register keeps one more; only then does req_tready drop. The state is
// updated only as a transaction moves into the response register.
//
// Reset (synchronous, active high) empties the pipeline, clears the filter,
// the engaged flag and both timers, and loads the default thresholds and dwell
// times. The csr port may be written at any time the block is idle.
module smoothed_rate_hysteresis_qualifier_top
   import srhq_pkg::*;
#(
   parameter int BLEND_ENTRIES = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata, from bit 0: rate_sample[15:0], elapsed_us[19:0], manual_on,
   // auto_on, two zero bits.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [39:0]           req_tdata,
   // rsp_tdata, from bit 0: filtered_rate[13:0], engaged_flag, effective_on.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [15:0]           rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Configuration registers.
   logic [FILT_W-1:0]  engage_rate_ff,   engage_rate_in;
   logic [FILT_W-1:0]  release_rate_ff,  release_rate_in;
   logic [TIMER_W-1:0] engage_dwell_ff,  engage_dwell_in;
   logic [TIMER_W-1:0] release_dwell_ff, release_dwell_in;

   // Input register.
   logic               s1_valid_ff,   s1_valid_in;
   logic [FILT_W-1:0]  s1_rate_ff,    s1_rate_in;
   logic [DT_W-1:0]    s1_elapsed_ff, s1_elapsed_in;
   logic               s1_manual_ff,  s1_manual_in;
   logic               s1_auto_ff,    s1_auto_in;

   // Filter and qualifier state.
   logic [SMOOTH_W-1:0] smooth_ff,   smooth_in;
   logic                primed_ff,   primed_in;
   logic                engaged_ff,  engaged_in;
   logic [TIMER_W-1:0]  low_time_ff, low_time_in;
   logic [TIMER_W-1:0]  rec_time_ff, rec_time_in;

   // Response register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_data_ff,  rsp_data_in;

   logic                req_fire;
   logic                advance;
   logic [RATE_W-1:0]   req_rate;
   logic [ELAPSED_W-1:0] req_elapsed;
   logic [SMOOTH_W-1:0] smooth_next;
   logic                primed_next;
   logic [TIMER_W:0]    low_sum;
   logic [TIMER_W:0]    rec_sum;
   logic [TIMER_W-1:0]  low_acc;
   logic [TIMER_W-1:0]  rec_acc;

   // The input register moves on when the response register is empty or is
   // being drained in this cycle.
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign req_rate    = req_tdata[RATE_W-1:0];
   assign req_elapsed = req_tdata[RATE_W+ELAPSED_W-1:RATE_W];

   srhq_filter #(
      .BLEND_ENTRIES (BLEND_ENTRIES)
   ) u_filter (
      .smooth      (smooth_ff),
      .primed      (primed_ff),
      .rate        (s1_rate_ff),
      .elapsed     (s1_elapsed_ff),
      .smooth_next (smooth_next),
      .primed_next (primed_next)
   );

   // Configuration writes; an index past the last register is ignored.
   always_comb begin
      engage_rate_in   = engage_rate_ff;
      release_rate_in  = release_rate_ff;
      engage_dwell_in  = engage_dwell_ff;
      release_dwell_in = release_dwell_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ENGAGE_RATE:   engage_rate_in   = csr_wdata[FILT_W-1:0];
            CSR_RELEASE_RATE:  release_rate_in  = csr_wdata[FILT_W-1:0];
            CSR_ENGAGE_DWELL:  engage_dwell_in  = csr_wdata[TIMER_W-1:0];
            CSR_RELEASE_DWELL: release_dwell_in = csr_wdata[TIMER_W-1:0];
            default: ;
         endcase
      end
   end

   // Input capture with clamping of the sample and the elapsed time.
   always_comb begin
      s1_valid_in   = s1_valid_ff;
      s1_rate_in    = s1_rate_ff;
      s1_elapsed_in = s1_elapsed_ff;
      s1_manual_in  = s1_manual_ff;
      s1_auto_in    = s1_auto_ff;
      if (advance) begin
         s1_valid_in = 1'b0;
      end
      if (req_fire) begin
         s1_valid_in   = 1'b1;
         s1_rate_in    = (req_rate > RATE_W'(RATE_MAX)) ?
                         FILT_W'(RATE_MAX) : req_rate[FILT_W-1:0];
         s1_elapsed_in = (req_elapsed > ELAPSED_W'(ELAPSED_MAX)) ?
                         DT_W'(ELAPSED_MAX) : req_elapsed[DT_W-1:0];
         s1_manual_in  = req_tdata[RATE_W+ELAPSED_W];
         s1_auto_in    = req_tdata[RATE_W+ELAPSED_W+1];
      end
   end

   // Saturating dwell timer sums.
   always_comb begin
      low_sum = {1'b0, low_time_ff} + (TIMER_W+1)'(s1_elapsed_ff);
      rec_sum = {1'b0, rec_time_ff} + (TIMER_W+1)'(s1_elapsed_ff);
      low_acc = low_sum[TIMER_W] ? TIMER_MAX : low_sum[TIMER_W-1:0];
      rec_acc = rec_sum[TIMER_W] ? TIMER_MAX : rec_sum[TIMER_W-1:0];
   end

   // One pass of the filter and the hysteresis qualifier per transaction.
   always_comb begin
      smooth_in    = smooth_ff;
      primed_in    = primed_ff;
      engaged_in   = engaged_ff;
      low_time_in  = low_time_ff;
      rec_time_in  = rec_time_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (advance) begin
         smooth_in = smooth_next;
         primed_in = primed_next;

         if (!s1_auto_ff) begin
            // Leaving automatic mode drops the flag and both timers.
            engaged_in  = 1'b0;
            low_time_in = '0;
            rec_time_in = '0;
         end else if (smooth_next != '0) begin
            // A filter sitting at zero leaves the qualifier untouched.
            if (!engaged_ff) begin
               if (smooth_next < {engage_rate_ff, 16'd0}) begin
                  low_time_in = low_acc;
                  if (low_acc >= engage_dwell_ff) begin
                     engaged_in  = 1'b1;
                     low_time_in = '0;
                     rec_time_in = '0;
                  end
               end else begin
                  low_time_in = '0;
               end
            end else begin
               if (smooth_next > {release_rate_ff, 16'd0}) begin
                  rec_time_in = rec_acc;
                  if (rec_acc >= release_dwell_ff) begin
                     engaged_in  = 1'b0;
                     rec_time_in = '0;
                     low_time_in = '0;
                  end
               end else begin
                  rec_time_in = '0;
               end
            end
         end

         rsp_valid_in = 1'b1;
         rsp_data_in  = {s1_manual_ff | engaged_in, engaged_in,
                         smooth_next[SMOOTH_W-1:16]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         engage_rate_ff   <= ENGAGE_RATE_RST;
         release_rate_ff  <= RELEASE_RATE_RST;
         engage_dwell_ff  <= ENGAGE_DWELL_RST;
         release_dwell_ff <= RELEASE_DWELL_RST;
         s1_valid_ff      <= 1'b0;
         smooth_ff        <= '0;
         primed_ff        <= 1'b0;
         engaged_ff       <= 1'b0;
         low_time_ff      <= '0;
         rec_time_ff      <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         engage_rate_ff   <= engage_rate_in;
         release_rate_ff  <= release_rate_in;
         engage_dwell_ff  <= engage_dwell_in;
         release_dwell_ff <= release_dwell_in;
         s1_valid_ff      <= s1_valid_in;
         smooth_ff        <= smooth_in;
         primed_ff        <= primed_in;
         engaged_ff       <= engaged_in;
         low_time_ff      <= low_time_in;
         rec_time_ff      <= rec_time_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      s1_rate_ff    <= s1_rate_in;
      s1_elapsed_ff <= s1_elapsed_in;
      s1_manual_ff  <= s1_manual_in;
      s1_auto_ff    <= s1_auto_in;
      rsp_data_ff   <= rsp_data_in;
   end

endmodule
